/* hw/rtl/rpc_pkg.sv */
// Shared types and constants for the reverse pair counter.
package rpc_pkg;

	localparam int MAX_ITEMS_DEF = 1024;
	localparam int VALUE_W       = 32;
	localparam int PAIR_W        = 19;
	localparam logic [PAIR_W-1:0] PAIR_MAX = {PAIR_W{1'b1}};

	typedef struct packed {
		logic signed [VALUE_W-1:0] value;
		logic                      last;
	} rpc_in_t;

	typedef struct packed {
		logic [PAIR_W-1:0] pair_count;
		logic              overflow;
	} rpc_out_t;

	// Control flags that travel with a query along the cell chain.
	typedef struct packed {
		logic valid;   // a query occupies this slot
		logic last;    // query closes the sequence
		logic full;    // store was full when the query entered
		logic placed;  // query value already written into a cell
	} rpc_ctl_t;

endpackage

/* hw/rtl/reverse_pair_counter.sv */
// Top level: counts pairs where an earlier value exceeds twice a later one.
//
//   channel   direction   handshake            payload
//   in        to block    in_valid / in_stall  rpc_in_t  (value, last)
//   out       from block  out_valid / out_stall rpc_out_t (pair_count, overflow)
//
// Each accepted item becomes a query that walks a chain of MAX_ITEMS cells,
// one cell per cycle. A cell either compares its stored value against twice
// the query value and bumps the query's hit count, or, if it is the first
// free cell, stores the query value. A query marked last clears every cell
// it passes, so the next sequence trails behind it into an empty chain.
//
// Flow: one item is taken every cycle unless the input stalls; the result for
// a last item appears once its query has passed the whole chain.
// Reset: arst_n clears cell valid flags, chain slots, totals and the result
// valid flag at once; no clearing pass is needed.
// Stalls: the chain and the input side hold only while a finished result
// waits in the output register and another last item reaches the chain end.
module reverse_pair_counter #(
	parameter int MAX_ITEMS = rpc_pkg::MAX_ITEMS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  rpc_pkg::rpc_in_t  in_data,
	output logic              out_valid,
	input  logic              out_stall,
	output rpc_pkg::rpc_out_t out_data
);
	import rpc_pkg::*;

	// Per-query hit count never exceeds MAX_ITEMS - 1.
	localparam int CNT_W  = $clog2(MAX_ITEMS);
	localparam int FILL_W = $clog2(MAX_ITEMS + 1);

	logic                      adv;
	logic                      accept;
	logic                      full;
	logic [FILL_W-1:0]         fill_q;
	rpc_ctl_t                  ctl   [0:MAX_ITEMS];
	logic signed [VALUE_W-1:0] value [0:MAX_ITEMS];
	logic [CNT_W-1:0]          count [0:MAX_ITEMS];

	assign in_stall = !adv;
	assign accept   = in_valid && adv;
	assign full     = (fill_q == FILL_W'(MAX_ITEMS));

	// Track how many items of the current sequence hold a cell.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (accept) begin
			if (in_data.last) begin
				fill_q <= '0;
			end else if (!full) begin
				fill_q <= fill_q + FILL_W'(1);
			end
		end
	end

	// Launch a query into the head of the chain; a bubble when nothing is taken.
	always_comb begin
		ctl[0].valid  = accept;
		ctl[0].last   = in_data.last;
		ctl[0].full   = full;
		ctl[0].placed = 1'b0;
	end
	assign value[0] = in_data.value;
	assign count[0] = '0;

	for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
		rpc_cell #(
			.CNT_W(CNT_W)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.adv      (adv),
			.in_ctl   (ctl[i]),
			.in_value (value[i]),
			.in_count (count[i]),
			.out_ctl  (ctl[i+1]),
			.out_value(value[i+1]),
			.out_count(count[i+1])
		);
	end

	// Drop query values at the chain end; only counts and flags matter there.
	rpc_tail #(
		.CNT_W(CNT_W)
	) u_tail (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_ctl   (ctl[MAX_ITEMS]),
		.in_count (count[MAX_ITEMS]),
		.out_stall(out_stall),
		.adv      (adv),
		.out_valid(out_valid),
		.out_data (out_data)
	);

endmodule

/* hw/rtl/rpc_cell.sv */
// One cell of the chain: holds one stored value and scores each passing query.
module rpc_cell #(
	parameter int CNT_W = 10
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              adv,
	input  rpc_pkg::rpc_ctl_t                 in_ctl,
	input  logic signed [rpc_pkg::VALUE_W-1:0] in_value,
	input  logic [CNT_W-1:0]                  in_count,
	output rpc_pkg::rpc_ctl_t                 out_ctl,
	output logic signed [rpc_pkg::VALUE_W-1:0] out_value,
	output logic [CNT_W-1:0]                  out_count
);
	import rpc_pkg::*;

	logic                      used_q;
	logic signed [VALUE_W-1:0] data_q;
	logic signed [VALUE_W:0]   lhs;
	logic signed [VALUE_W:0]   rhs;
	logic                      active;
	logic                      hit;
	logic                      take;
	logic                      clear;
	rpc_ctl_t                  ctl_nxt;
	rpc_ctl_t                  ctl_q;
	logic signed [VALUE_W-1:0] value_q;
	logic [CNT_W-1:0]          count_q;

	// Stored value against twice the query value, exact in 33 bits.
	assign lhs    = {data_q[VALUE_W-1], data_q};
	assign rhs    = {in_value, 1'b0};
	assign active = in_ctl.valid && !in_ctl.full;
	assign hit    = active && used_q && (lhs > rhs);
	assign take   = active && !in_ctl.last && !in_ctl.placed && !used_q;
	assign clear  = in_ctl.valid && in_ctl.last;

	always_comb begin
		ctl_nxt        = in_ctl;
		ctl_nxt.placed = in_ctl.placed || take;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= 1'b0;
			ctl_q  <= '0;
		end else if (adv) begin
			ctl_q <= ctl_nxt;
			if (clear) begin
				used_q <= 1'b0;
			end else if (take) begin
				used_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			value_q <= in_value;
			count_q <= in_count + CNT_W'(hit);
			if (take) begin
				data_q <= in_value;
			end
		end
	end

	assign out_ctl   = ctl_q;
	assign out_value = value_q;
	assign out_count = count_q;

endmodule

/* hw/rtl/rpc_tail.sv */
// Chain exit: running total, overflow flag and the result register.
module rpc_tail #(
	parameter int CNT_W = 10
) (
	input  logic              clk,
	input  logic              arst_n,
	input  rpc_pkg::rpc_ctl_t in_ctl,
	input  logic [CNT_W-1:0]  in_count,
	input  logic              out_stall,
	output logic              adv,
	output logic              out_valid,
	output rpc_pkg::rpc_out_t out_data
);
	import rpc_pkg::*;

	localparam int SUM_W = PAIR_W + 1;

	logic [PAIR_W-1:0] run_q;
	logic              ovf_q;
	logic              out_valid_q;
	rpc_out_t          out_q;
	logic [SUM_W-1:0]  sum;
	logic [PAIR_W-1:0] sat;
	logic              ovf_nxt;
	logic              exits;

	// Only a closing query needs the result register; hold the chain when it is busy.
	assign adv     = !(out_valid_q && out_stall) || !(in_ctl.valid && in_ctl.last);
	assign exits   = adv && in_ctl.valid;
	assign sum     = {1'b0, run_q} + {{(SUM_W-CNT_W){1'b0}}, in_count};
	assign sat     = sum[PAIR_W] ? PAIR_MAX : sum[PAIR_W-1:0];
	assign ovf_nxt = ovf_q || in_ctl.full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q       <= '0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (exits && in_ctl.last) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (exits) begin
				if (in_ctl.last) begin
					run_q <= '0;
					ovf_q <= 1'b0;
				end else begin
					run_q <= sat;
					ovf_q <= ovf_nxt;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (exits && in_ctl.last) begin
			out_q.pair_count <= sat;
			out_q.overflow   <= ovf_nxt;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

/* hw/rtl/rpc_checker.sv */
// Port-level checks for the reverse pair counter, bound to the top level.
module rpc_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_stall,
	input rpc_pkg::rpc_in_t  in_data,
	input logic              out_valid,
	input logic              out_stall,
	input rpc_pkg::rpc_out_t out_data
);
	import rpc_pkg::*;

	// A stalled result holds until taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// The input side only stalls behind a waiting, stalled result.
	a_in_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without a pending result");

	// Reset empties the result register.
	a_reset_empty: assert property (@(posedge clk)
		!arst_n |-> !out_valid)
		else $error("result valid during reset");

	// An input item offered under stall stays offered and unchanged.
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid && $stable(in_data))
		else $error("input item changed while stalled");

endmodule

bind reverse_pair_counter rpc_checker u_rpc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (in_valid),
	.in_stall (in_stall),
	.in_data  (in_data),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.out_data (out_data)
);

/* tb/sv/reverse_pair_counter_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the reverse pair counter: predicted totals checked per sequence.
module reverse_pair_counter_tb;
	import rpc_pkg::*;

	localparam int MAX_ITEMS   = MAX_ITEMS_DEF;
	// A last item needs the whole chain to report; allow that plus some slack.
	localparam int LATENCY     = MAX_ITEMS;
	localparam int DRAIN_WAIT  = LATENCY + 40;
	// The longest quiet stretch of a correct run comes from the long receiver
	// hold-off or, under heavy stalling, from a last item crossing the chain.
	localparam int QUIET_LIMIT = 12000;
	localparam int HOLD_CYCLES = 2500;
	localparam int PHASE_ITEMS = 90;

	// Tracks one open sequence and the totals it must produce.
	class pair_tally;
		logic signed [VALUE_W-1:0] seen_values[$];
		logic [PAIR_W-1:0]         pairs;
		bit                        dropped;
		rpc_out_t                  totals_q[$];
		int                        errors;

		function new();
			pairs   = '0;
			dropped = 1'b0;
			errors  = 0;
		endfunction

		function int pending();
			return totals_q.size();
		endfunction

		// Fold one accepted item into the open sequence; queue a total on last.
		function void note_item(rpc_in_t it);
			logic signed [VALUE_W+1:0] twice;
			int hits;
			rpc_out_t total;
			twice = $signed(it.value);
			twice = twice <<< 1;
			if (seen_values.size() < MAX_ITEMS) begin
				hits = 0;
				foreach (seen_values[k])
					if ($signed(seen_values[k]) > twice)
						hits++;
				if (hits > int'(PAIR_MAX) - int'(pairs))
					pairs = PAIR_MAX;
				else
					pairs = pairs + PAIR_W'(hits);
				seen_values.push_back(it.value);
			end else begin
				dropped = 1'b1;
			end
			if (it.last) begin
				total.pair_count = pairs;
				total.overflow   = dropped;
				totals_q.push_back(total);
				seen_values.delete();
				pairs   = '0;
				dropped = 1'b0;
			end
		endfunction

		// Compare one accepted result with the oldest queued total.
		function void check_result(rpc_out_t got);
			rpc_out_t want;
			if (totals_q.size() == 0) begin
				$error("unexpected result: pair_count=%0d overflow=%0d",
					got.pair_count, got.overflow);
				errors++;
				return;
			end
			want = totals_q.pop_front();
			if (got.pair_count !== want.pair_count) begin
				$error("pair_count: expected %0d, got %0d", want.pair_count, got.pair_count);
				errors++;
			end
			if (got.overflow !== want.overflow) begin
				$error("overflow: expected %0d, got %0d", want.overflow, got.overflow);
				errors++;
			end
		endfunction
	endclass

	logic     clk;
	logic     arst_n;
	logic     in_valid;
	logic     in_stall;
	rpc_in_t  in_data;
	logic     out_valid;
	logic     out_stall;
	rpc_out_t out_data;

	pair_tally sb;

	// Idle percentages for the current phase, and the hold-off request.
	int  tx_pct;
	int  rx_pct;
	bit  hold_req;
	int  hold_left;
	int  quiet_cycles;
	bit  in_blocked;
	logic signed [VALUE_W-1:0] prev_value;

	reverse_pair_counter #(
		.MAX_ITEMS(MAX_ITEMS)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	// Receiver: honor a long hold-off when asked, otherwise stall at random.
	always @(posedge clk) begin
		if (hold_req) begin
			hold_left = HOLD_CYCLES;
			hold_req  = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(0, 99) < rx_pct);
		end
	end

	// Monitor both channels on the edge values and keep the watchdog.
	always @(posedge clk) begin
		if (arst_n) begin
			quiet_cycles++;
			if (out_valid && !out_stall) begin
				sb.check_result(out_data);
				quiet_cycles = 0;
			end
			if (in_valid && !in_stall) begin
				sb.note_item(in_data);
				quiet_cycles = 0;
			end
			if (in_valid && in_stall)
				in_blocked = 1'b1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("reverse_pair_counter_tb: FAIL");
				$finish;
			end
		end
	end

	// Pick a value: full range, small, extremes, random magnitude, or near half of
	// the previous one so that the strict "greater than twice" boundary gets hit.
	function automatic logic signed [VALUE_W-1:0] pick_value();
		logic signed [VALUE_W-1:0] v;
		case ($urandom_range(0, 6))
			0, 1: v = $urandom();
			2: v = $signed($urandom_range(0, 40)) - 20;
			3: begin
				case ($urandom_range(0, 3))
					0: v = 32'sh7FFF_FFFF;
					1: v = 32'sh8000_0000;
					2: v = '0;
					default: v = -1;
				endcase
			end
			4: v = prev_value >>> 1;
			5: v = (prev_value >>> 1) + ($signed($urandom_range(0, 2)) - 1);
			default: v = $signed($urandom()) >>> $urandom_range(0, 31);
		endcase
		prev_value = v;
		return v;
	endfunction

	// Offer one item, idling first at the phase rate; hold it until taken.
	task automatic send_item(input logic signed [VALUE_W-1:0] v, input logic is_last);
		rpc_in_t it;
		it.value = v;
		it.last  = is_last;
		while ($urandom_range(0, 99) < tx_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= it;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	task automatic send_sequence(input int len);
		for (int k = 0; k < len; k++)
			send_item(pick_value(), k == len - 1);
	endtask

	task automatic wait_drained();
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	// Mostly short sequences, now and then a longer one.
	function automatic int pick_length();
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(40, 150);
		return $urandom_range(1, 20);
	endfunction

	initial begin
		int sent;
		int len;
		sb           = new();
		tx_pct       = 0;
		rx_pct       = 0;
		hold_req     = 1'b0;
		hold_left    = 0;
		quiet_cycles = 0;
		in_blocked   = 1'b0;
		prev_value   = '0;
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		in_data      = '0;
		out_stall    = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Length-one sequences: nothing stored, total is zero.
		send_item(32'sd0, 1'b1);
		send_item(32'sh8000_0000, 1'b1);
		// Extremes against each other.
		send_item(32'sh7FFF_FFFF, 1'b0);
		send_item(32'sh8000_0000, 1'b0);
		send_item(32'sh4000_0000, 1'b0);
		send_item(-32'sd1, 1'b1);
		// Ties: equal to twice the later value does not count.
		send_item(32'sd4, 1'b0);
		send_item(32'sd2, 1'b0);
		send_item(32'sd1, 1'b0);
		send_item(32'sd0, 1'b1);
		// Negative boundary, where doubling leaves 32 bits.
		send_item(32'sh8000_0000, 1'b0);
		send_item(32'shC000_0000, 1'b0);
		send_item(32'shBFFF_FFFF, 1'b0);
		send_item(32'shFFFF_FFFF, 1'b1);
		// Positive boundary near half the largest value.
		send_item(32'sh7FFF_FFFF, 1'b0);
		send_item(32'sh3FFF_FFFF, 1'b0);
		send_item(32'sh4000_0000, 1'b0);
		send_item(32'sh0000_0001, 1'b1);

		// Fill the store exactly, then overrun so the closing item is dropped too.
		send_sequence(MAX_ITEMS + 3);

		// Hold the receiver off while short sequences trickle in; once two
		// totals reach the chain end the block stalls its input. Keep offering
		// until that stall has been seen.
		tx_pct     = 90;
		in_blocked = 1'b0;
		hold_req   = 1'b1;
		while (!in_blocked) begin
			len = $urandom_range(1, 4);
			send_sequence(len);
		end
		in_valid <= 1'b0;
		tx_pct = 0;
		wait_drained();

		// Idling phases: none, sender idle, receiver stalling, both.
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin tx_pct = 0;  rx_pct = 0;  end
				1: begin tx_pct = 75; rx_pct = 0;  end
				2: begin tx_pct = 0;  rx_pct = 75; end
				default: begin tx_pct = 33; rx_pct = 33; end
			endcase
			sent = 0;
			while (sent < PHASE_ITEMS) begin
				len = pick_length();
				send_sequence(len);
				sent += len;
				// In the sender-idle phase, once mid-phase, pause the sender until every total is back.
				if (phase == 1 && sent >= PHASE_ITEMS / 2 && sent - len < PHASE_ITEMS / 2) begin
					in_valid <= 1'b0;
					wait_drained();
				end
			end
		end
		in_valid <= 1'b0;
		tx_pct = 0;
		rx_pct = 0;

		wait_drained();
		repeat (DRAIN_WAIT) @(posedge clk);
		if (sb.pending() != 0) begin
			$error("%0d expected results never arrived", sb.pending());
			sb.errors++;
		end
		if (sb.errors == 0)
			$display("reverse_pair_counter_tb: PASS");
		else
			$display("reverse_pair_counter_tb: FAIL");
		$finish;
	end

endmodule

/* sim.f */
hw/rtl/rpc_pkg.sv
hw/rtl/rpc_cell.sv
hw/rtl/rpc_tail.sv
hw/rtl/reverse_pair_counter.sv
hw/rtl/rpc_checker.sv
tb/sv/reverse_pair_counter_tb.sv
